@@ hdl/vock_pkg.sv @@
// Shared widths, register map, format and keyer codes for the overlay color-key mixer.
`default_nettype none
package vock_pkg;

  // Field widths
  localparam int unsigned CoordW = 11;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned FmtW   = 4;
  localparam int unsigned WinW   = 27;
  localparam int unsigned KeyCtlW = 9;

  // Configuration port
  localparam int unsigned AddrW   = 5;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_SOURCE_FORMAT = 3'd0,
    REG_WINDOW_START  = 3'd1,
    REG_WINDOW_END    = 3'd2,
    REG_KEY_CONTROL   = 3'd3,
    REG_VIDEO_KEY     = 3'd4,
    REG_VIDEO_MASK    = 3'd5,
    REG_GFX_KEY       = 3'd6,
    REG_GFX_MASK      = 3'd7
  } reg_idx_t;

  // Source format codes
  localparam logic [FmtW-1:0] FMT_RGB1555 = 4'd3;
  localparam logic [FmtW-1:0] FMT_RGB8888 = 4'd6;
  localparam logic [FmtW-1:0] FMT_PLANAR0 = 4'd9;
  localparam logic [FmtW-1:0] FMT_PLANAR1 = 4'd10;
  localparam logic [FmtW-1:0] FMT_YUY2    = 4'd11;
  localparam logic [FmtW-1:0] FMT_UYVY    = 4'd12;

  // Keyer function codes; all others mean never
  localparam logic [2:0] KEY_ALWAYS = 3'd1;
  localparam logic [2:0] KEY_NEQ    = 3'd4;
  localparam logic [2:0] KEY_EQ     = 3'd5;

  // Color conversion offsets
  localparam logic signed [10:0] OFS_RED   = 11'sd218;
  localparam logic signed [10:0] OFS_GREEN = 11'sd136;
  localparam logic signed [10:0] OFS_BLUE  = 11'sd274;

endpackage
`default_nettype wire

@@ hdl/vock_in_if.sv @@
// Input pixel channel: coordinate, overlay source word and graphics pixel.
`default_nettype none
interface vock_in_if;
  logic                           valid;
  logic                           ready;
  logic [vock_pkg::CoordW-1:0]    screen_x;
  logic [vock_pkg::CoordW-1:0]    screen_y;
  logic [vock_pkg::WordW-1:0]     source_word;
  logic                           odd_pixel;
  logic [vock_pkg::WordW-1:0]     graphics_pixel;

  modport source (
    output valid, screen_x, screen_y, source_word, odd_pixel, graphics_pixel,
    input  ready
  );
  modport sink (
    input  valid, screen_x, screen_y, source_word, odd_pixel, graphics_pixel,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/vock_out_if.sv @@
// Output pixel channel: replace flag and decoded video color.
`default_nettype none
interface vock_out_if;
  logic                        valid;
  logic                        ready;
  logic                        replace;
  logic [vock_pkg::ChanW-1:0]  red;
  logic [vock_pkg::ChanW-1:0]  green;
  logic [vock_pkg::ChanW-1:0]  blue;

  modport source (
    output valid, replace, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, replace, red, green, blue,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/video_overlay_color_key_mixer_core.sv @@
// Top level of the overlay color-key mixer: register file and three-stage pixel pipeline.
// Each input transfer is registered in stage 1, then stage 2, then the output register.
// Throughput: one pixel per cycle; stage 1 decodes and keys, stage 2 forms the scaled
// YUV terms, stage 3 sums, clamps and selects the color into the output register.
// A stall at the output holds every stage in place; bubbles are filled as they move up.
// Reset (rst, synchronous) clears all configuration registers and the stage valid bits.
`default_nettype none
module video_overlay_color_key_mixer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [vock_pkg::AddrW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  vock_in_if.sink                            pix_in,
  vock_out_if.source                         pix_out
);

  // Configuration registers
  logic [vock_pkg::FmtW-1:0]    source_format;
  logic [vock_pkg::WinW-1:0]    window_start;
  logic [vock_pkg::WinW-1:0]    window_end;
  logic [vock_pkg::KeyCtlW-1:0] key_control;
  logic [31:0]                  video_key_color;
  logic [31:0]                  video_key_mask;
  logic [31:0]                  graphics_key_color;
  logic [31:0]                  graphics_key_mask;

  logic                         cfg_wr;
  vock_pkg::reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = vock_pkg::reg_idx_t'(paddr[vock_pkg::AddrW-1:2]);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format      <= '0;
      window_start       <= '0;
      window_end         <= '0;
      key_control        <= '0;
      video_key_color    <= '0;
      video_key_mask     <= '0;
      graphics_key_color <= '0;
      graphics_key_mask  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vock_pkg::REG_SOURCE_FORMAT: source_format      <= pwdata[vock_pkg::FmtW-1:0];
        vock_pkg::REG_WINDOW_START:  window_start       <= pwdata[vock_pkg::WinW-1:0];
        vock_pkg::REG_WINDOW_END:    window_end         <= pwdata[vock_pkg::WinW-1:0];
        vock_pkg::REG_KEY_CONTROL:   key_control        <= pwdata[vock_pkg::KeyCtlW-1:0];
        vock_pkg::REG_VIDEO_KEY:     video_key_color    <= pwdata;
        vock_pkg::REG_VIDEO_MASK:    video_key_mask     <= pwdata;
        vock_pkg::REG_GFX_KEY:       graphics_key_color <= pwdata;
        vock_pkg::REG_GFX_MASK:      graphics_key_mask  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (cfg_idx)
      vock_pkg::REG_SOURCE_FORMAT: prdata = 32'(source_format);
      vock_pkg::REG_WINDOW_START:  prdata = 32'(window_start);
      vock_pkg::REG_WINDOW_END:    prdata = 32'(window_end);
      vock_pkg::REG_KEY_CONTROL:   prdata = 32'(key_control);
      vock_pkg::REG_VIDEO_KEY:     prdata = video_key_color;
      vock_pkg::REG_VIDEO_MASK:    prdata = video_key_mask;
      vock_pkg::REG_GFX_KEY:       prdata = graphics_key_color;
      vock_pkg::REG_GFX_MASK:      prdata = graphics_key_mask;
      default:                     prdata = '0;
    endcase
  end

  // Stage advance: a stage moves when it is empty or the stage after it moves
  logic s1_valid, s2_valid, out_valid;
  logic adv1, adv2, adv3;

  assign adv3 = !out_valid || pix_out.ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign pix_in.ready = adv1;

  // Stage 1 logic: decode source, test window and keyers
  logic [7:0]  dec_y, dec_u, dec_v;
  logic        dec_yuv;
  logic [7:0]  dec_r, dec_g, dec_b;
  logic [31:0] dec_raw;
  logic [4:0]  f5_r, f5_g, f5_b;
  logic [5:0]  f6_g;
  logic [10:0] win_x0, win_y0, win_x1, win_y1;
  logic        win_inside;
  logic        key_v, key_g, key_hit;

  always_comb begin
    dec_y   = '0;
    dec_u   = '0;
    dec_v   = '0;
    dec_yuv = 1'b0;
    f5_r    = '0;
    f5_g    = '0;
    f6_g    = '0;
    f5_b    = pix_in.source_word[4:0];
    dec_r   = '0;
    dec_g   = '0;
    dec_b   = '0;
    dec_raw = {16'd0, pix_in.source_word[15:0]};
    unique case (source_format)
      vock_pkg::FMT_PLANAR0, vock_pkg::FMT_PLANAR1: begin
        dec_yuv = 1'b1;
        dec_y   = pix_in.source_word[23:16];
        dec_u   = pix_in.source_word[15:8];
        dec_v   = pix_in.source_word[7:0];
        dec_raw = {8'd0, pix_in.source_word[23:0]};
      end
      vock_pkg::FMT_YUY2: begin
        dec_yuv = 1'b1;
        dec_y   = pix_in.odd_pixel ? pix_in.source_word[23:16] : pix_in.source_word[7:0];
        dec_u   = pix_in.source_word[15:8];
        dec_v   = pix_in.source_word[31:24];
        dec_raw = {8'd0, dec_y, dec_u, dec_v};
      end
      vock_pkg::FMT_UYVY: begin
        dec_yuv = 1'b1;
        dec_y   = pix_in.odd_pixel ? pix_in.source_word[31:24] : pix_in.source_word[15:8];
        dec_u   = pix_in.source_word[7:0];
        dec_v   = pix_in.source_word[23:16];
        dec_raw = {8'd0, dec_y, dec_u, dec_v};
      end
      vock_pkg::FMT_RGB8888: begin
        dec_raw = pix_in.source_word;
        dec_r   = pix_in.source_word[23:16];
        dec_g   = pix_in.source_word[15:8];
        dec_b   = pix_in.source_word[7:0];
      end
      vock_pkg::FMT_RGB1555: begin
        f5_r  = pix_in.source_word[14:10];
        f5_g  = pix_in.source_word[9:5];
        dec_r = {f5_r, f5_r[4:2]};
        dec_g = {f5_g, f5_g[4:2]};
        dec_b = {f5_b, f5_b[4:2]};
      end
      default: begin
        f5_r  = pix_in.source_word[15:11];
        f6_g  = pix_in.source_word[10:5];
        dec_r = {f5_r, f5_r[4:2]};
        dec_g = {f6_g, f6_g[5:4]};
        dec_b = {f5_b, f5_b[4:2]};
      end
    endcase
  end

  assign win_x0 = window_start[26:16];
  assign win_y0 = window_start[10:0];
  assign win_x1 = window_end[26:16];
  assign win_y1 = window_end[10:0];
  assign win_inside = (pix_in.screen_x >= win_x0) && (pix_in.screen_x <= win_x1) &&
                      (pix_in.screen_y >= win_y0) && (pix_in.screen_y <= win_y1);

  // Masked keyer test
  function automatic logic key_test(input logic [2:0] fn, input logic [31:0] c,
                                    input logic [31:0] key, input logic [31:0] msk);
    logic same;
    same = ((c ^ key) & msk) == 32'd0;
    unique case (fn)
      vock_pkg::KEY_ALWAYS: key_test = 1'b1;
      vock_pkg::KEY_NEQ:    key_test = !same;
      vock_pkg::KEY_EQ:     key_test = same;
      default:              key_test = 1'b0;
    endcase
  endfunction

  assign key_v   = key_test(key_control[2:0], dec_raw, video_key_color, video_key_mask);
  assign key_g   = key_test(key_control[6:4], pix_in.graphics_pixel,
                            graphics_key_color, graphics_key_mask);
  assign key_hit = key_control[8] ? (key_v && key_g) : (key_v || key_g);

  // Stage 1 registers
  logic       s1_yuv, s1_replace;
  logic [7:0] s1_y, s1_u, s1_v, s1_r, s1_g, s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && pix_in.valid) begin
      s1_yuv     <= dec_yuv;
      s1_replace <= win_inside && key_hit;
      s1_y       <= dec_y;
      s1_u       <= dec_u;
      s1_v       <= dec_v;
      s1_r       <= dec_r;
      s1_g       <= dec_g;
      s1_b       <= dec_b;
    end
  end

  // Stage 2 logic: scaled YUV terms, floor divisions as shifts
  logic [11:0] y9, v13;
  logic [12:0] v25, u25;
  logic [8:0]  t_ys, t_rv, t_bu;
  logic [7:0]  t_gv;
  logic [6:0]  t_gu;

  assign y9   = {1'b0, s1_y, 3'd0} + {4'd0, s1_y};
  assign v25  = {1'b0, s1_v, 4'd0} + {2'd0, s1_v, 3'd0} + {5'd0, s1_v};
  assign v13  = {1'b0, s1_v, 3'd0} + {2'd0, s1_v, 2'd0} + {4'd0, s1_v};
  assign u25  = {1'b0, s1_u, 4'd0} + {2'd0, s1_u, 3'd0} + {5'd0, s1_u};
  assign t_ys = y9[11:3];
  assign t_rv = v25[12:4];
  assign t_gv = v13[11:4];
  assign t_gu = u25[12:6];
  assign t_bu = {s1_u, 1'b0};

  // Stage 2 registers
  logic       s2_yuv, s2_replace;
  logic [8:0] s2_ys, s2_rv, s2_bu;
  logic [7:0] s2_gv;
  logic [6:0] s2_gu;
  logic [7:0] s2_r, s2_g, s2_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_yuv     <= s1_yuv;
      s2_replace <= s1_replace;
      s2_ys      <= t_ys;
      s2_rv      <= t_rv;
      s2_gv      <= t_gv;
      s2_gu      <= t_gu;
      s2_bu      <= t_bu;
      s2_r       <= s1_r;
      s2_g       <= s1_g;
      s2_b       <= s1_b;
    end
  end

  // Stage 3 logic: sum, clamp to 0..255, pick the color
  logic signed [10:0] sum_r, sum_g, sum_b;
  logic [7:0]         sat_r, sat_g, sat_b;

  function automatic logic [7:0] sat8(input logic signed [10:0] v);
    if (v[10]) begin
      sat8 = 8'd0;
    end else if (|v[9:8]) begin
      sat8 = 8'd255;
    end else begin
      sat8 = v[7:0];
    end
  endfunction

  assign sum_r = $signed({2'b00, s2_ys}) + $signed({2'b00, s2_rv}) - vock_pkg::OFS_RED;
  assign sum_g = $signed({2'b00, s2_ys}) - $signed({3'b000, s2_gv})
               - $signed({4'b0000, s2_gu}) + vock_pkg::OFS_GREEN;
  assign sum_b = $signed({2'b00, s2_ys}) + $signed({2'b00, s2_bu}) - vock_pkg::OFS_BLUE;
  assign sat_r = sat8(sum_r);
  assign sat_g = sat8(sum_g);
  assign sat_b = sat8(sum_b);

  // Output register
  logic       out_replace;
  logic [7:0] out_r, out_g, out_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      out_replace <= s2_replace;
      out_r       <= s2_yuv ? sat_r : s2_r;
      out_g       <= s2_yuv ? sat_g : s2_g;
      out_b       <= s2_yuv ? sat_b : s2_b;
    end
  end

  assign pix_out.valid   = out_valid;
  assign pix_out.replace = out_replace;
  assign pix_out.red     = out_r;
  assign pix_out.green   = out_g;
  assign pix_out.blue    = out_b;

endmodule
`default_nettype wire
